>>> src/rvid_pkg.sv
package rvid_pkg;

    localparam int XLEN      = 32;
    localparam int KIND_W    = 6;
    localparam int REG_W     = 5;
    localparam int CSR_W     = 12;
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 104;

    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6f;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    localparam logic [2:0] F3_ADD = 3'd0;
    localparam logic [2:0] F3_SR  = 3'd5;

    localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
    localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;

    localparam logic [5:0] OP_ILLEGAL = 6'd0;
    localparam logic [5:0] OP_LUI     = 6'd1;
    localparam logic [5:0] OP_AUIPC   = 6'd2;
    localparam logic [5:0] OP_JAL     = 6'd3;
    localparam logic [5:0] OP_JALR    = 6'd4;
    localparam logic [5:0] OP_BEQ     = 6'd5;
    localparam logic [5:0] OP_BNE     = 6'd6;
    localparam logic [5:0] OP_BLT     = 6'd7;
    localparam logic [5:0] OP_BGE     = 6'd8;
    localparam logic [5:0] OP_BLTU    = 6'd9;
    localparam logic [5:0] OP_BGEU    = 6'd10;
    localparam logic [5:0] OP_LB      = 6'd11;
    localparam logic [5:0] OP_LH      = 6'd12;
    localparam logic [5:0] OP_LW      = 6'd13;
    localparam logic [5:0] OP_LBU     = 6'd14;
    localparam logic [5:0] OP_LHU     = 6'd15;
    localparam logic [5:0] OP_SB      = 6'd16;
    localparam logic [5:0] OP_SH      = 6'd17;
    localparam logic [5:0] OP_SW      = 6'd18;
    localparam logic [5:0] OP_ADDI    = 6'd19;
    localparam logic [5:0] OP_SLTI    = 6'd20;
    localparam logic [5:0] OP_SLTIU   = 6'd21;
    localparam logic [5:0] OP_XORI    = 6'd22;
    localparam logic [5:0] OP_ORI     = 6'd23;
    localparam logic [5:0] OP_ANDI    = 6'd24;
    localparam logic [5:0] OP_SLLI    = 6'd25;
    localparam logic [5:0] OP_SRLI    = 6'd26;
    localparam logic [5:0] OP_SRAI    = 6'd27;
    localparam logic [5:0] OP_ADD     = 6'd28;
    localparam logic [5:0] OP_SUB     = 6'd29;
    localparam logic [5:0] OP_SLL     = 6'd30;
    localparam logic [5:0] OP_SLT     = 6'd31;
    localparam logic [5:0] OP_SLTU    = 6'd32;
    localparam logic [5:0] OP_XOR     = 6'd33;
    localparam logic [5:0] OP_SRL     = 6'd34;
    localparam logic [5:0] OP_SRA     = 6'd35;
    localparam logic [5:0] OP_OR      = 6'd36;
    localparam logic [5:0] OP_AND     = 6'd37;
    localparam logic [5:0] OP_ECALL   = 6'd38;
    localparam logic [5:0] OP_EBREAK  = 6'd39;
    localparam logic [5:0] OP_CSRRW   = 6'd40;
    localparam logic [5:0] OP_CSRRS   = 6'd41;
    localparam logic [5:0] OP_CSRRC   = 6'd42;
    localparam logic [5:0] OP_CSRRWI  = 6'd43;
    localparam logic [5:0] OP_CSRRSI  = 6'd44;
    localparam logic [5:0] OP_CSRRCI  = 6'd45;

    typedef struct packed {
        logic [CSR_W-1:0]       csr_number;
        logic [XLEN-1:0]        branch_target;
        logic signed [XLEN-1:0] immediate;
        logic [REG_W-1:0]       src_reg_b;
        logic [REG_W-1:0]       src_reg_a;
        logic [REG_W-1:0]       dest_reg;
        logic [KIND_W-1:0]      op_kind;
    } decode_t;

    function automatic logic [5:0] branch_kind(input logic [2:0] f3);
        logic [5:0] k;
        case (f3)
            3'd0:    k = OP_BEQ;
            3'd1:    k = OP_BNE;
            3'd4:    k = OP_BLT;
            3'd5:    k = OP_BGE;
            3'd6:    k = OP_BLTU;
            3'd7:    k = OP_BGEU;
            default: k = OP_ILLEGAL;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] load_kind(input logic [2:0] f3);
        logic [5:0] k;
        case (f3)
            3'd0:    k = OP_LB;
            3'd1:    k = OP_LH;
            3'd2:    k = OP_LW;
            3'd4:    k = OP_LBU;
            3'd5:    k = OP_LHU;
            default: k = OP_ILLEGAL;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] store_kind(input logic [2:0] f3);
        logic [5:0] k;
        case (f3)
            3'd0:    k = OP_SB;
            3'd1:    k = OP_SH;
            3'd2:    k = OP_SW;
            default: k = OP_ILLEGAL;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] aluimm_kind(input logic [2:0] f3);
        logic [5:0] k;
        case (f3)
            3'd0:    k = OP_ADDI;
            3'd1:    k = OP_SLLI;
            3'd2:    k = OP_SLTI;
            3'd3:    k = OP_SLTIU;
            3'd4:    k = OP_XORI;
            3'd6:    k = OP_ORI;
            3'd7:    k = OP_ANDI;
            default: k = OP_ILLEGAL;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] alureg_kind(input logic [2:0] f3);
        logic [5:0] k;
        case (f3)
            3'd0:    k = OP_ADD;
            3'd1:    k = OP_SLL;
            3'd2:    k = OP_SLT;
            3'd3:    k = OP_SLTU;
            3'd4:    k = OP_XOR;
            3'd5:    k = OP_SRL;
            3'd6:    k = OP_OR;
            3'd7:    k = OP_AND;
            default: k = OP_ILLEGAL;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] csr_kind(input logic [2:0] f3);
        logic [5:0] k;
        case (f3)
            3'd1:    k = OP_CSRRW;
            3'd2:    k = OP_CSRRS;
            3'd3:    k = OP_CSRRC;
            3'd5:    k = OP_CSRRWI;
            3'd6:    k = OP_CSRRSI;
            3'd7:    k = OP_CSRRCI;
            default: k = OP_ILLEGAL;
        endcase
        return k;
    endfunction

endpackage

>>> src/rvid_decode.sv
module rvid_decode
    import rvid_pkg::*;
(
    input  logic [XLEN-1:0] instr_addr,
    input  logic [XLEN-1:0] instr_word,
    output decode_t         dec
);

    logic [6:0]      opc;
    logic [2:0]      f3;
    logic [6:0]      f7;
    logic [XLEN-1:0] imm_i;
    logic [XLEN-1:0] imm_s;
    logic [XLEN-1:0] imm_b;
    logic [XLEN-1:0] imm_j;
    logic [XLEN-1:0] imm_u;
    logic [XLEN-1:0] imm;
    logic [XLEN-1:0] target;
    logic [5:0]      kind;
    logic [4:0]      rd;
    logic [4:0]      ra;
    logic [4:0]      rb;
    logic [11:0]     csr;
    logic            use_tgt;

    assign opc = instr_word[6:0];
    assign f3  = instr_word[14:12];
    assign f7  = instr_word[31:25];

    assign imm_i = {{20{instr_word[31]}}, instr_word[31:20]};
    assign imm_s = {{20{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};
    assign imm_b = {{20{instr_word[31]}}, instr_word[7], instr_word[30:25],
                    instr_word[11:8], 1'b0};
    assign imm_j = {{12{instr_word[31]}}, instr_word[19:12], instr_word[20],
                    instr_word[30:21], 1'b0};
    assign imm_u = {instr_word[31:12], 12'h000};

    always_comb
    begin
        kind    = OP_ILLEGAL;
        rd      = '0;
        ra      = '0;
        rb      = '0;
        imm     = '0;
        csr     = '0;
        use_tgt = 1'b0;
        case (opc)
            OPC_LUI, OPC_AUIPC:
            begin
                kind = (opc == OPC_LUI) ? OP_LUI : OP_AUIPC;
                rd   = instr_word[11:7];
                imm  = imm_u;
            end
            OPC_JAL:
            begin
                kind    = OP_JAL;
                rd      = instr_word[11:7];
                imm     = imm_j;
                use_tgt = 1'b1;
            end
            OPC_JALR:
            begin
                if (f3 == F3_ADD)
                begin
                    kind = OP_JALR;
                    rd   = instr_word[11:7];
                    ra   = instr_word[19:15];
                    imm  = imm_i;
                end
            end
            OPC_BRANCH:
            begin
                kind    = branch_kind(f3);
                ra      = instr_word[19:15];
                rb      = instr_word[24:20];
                imm     = imm_b;
                use_tgt = 1'b1;
            end
            OPC_LOAD:
            begin
                kind = load_kind(f3);
                rd   = instr_word[11:7];
                ra   = instr_word[19:15];
                imm  = imm_i;
            end
            OPC_STORE:
            begin
                kind = store_kind(f3);
                ra   = instr_word[19:15];
                rb   = instr_word[24:20];
                imm  = imm_s;
            end
            OPC_OPIMM:
            begin
                rd  = instr_word[11:7];
                ra  = instr_word[19:15];
                imm = imm_i;
                if (f3 == F3_SR)
                begin
                    if (f7 == F7_BASE)
                    begin
                        kind = OP_SRLI;
                    end
                    else if (f7 == F7_ALT)
                    begin
                        kind = OP_SRAI;
                        imm  = {27'd0, instr_word[24:20]};
                    end
                end
                else
                begin
                    kind = aluimm_kind(f3);
                end
            end
            OPC_OP:
            begin
                rd = instr_word[11:7];
                ra = instr_word[19:15];
                rb = instr_word[24:20];
                if (f7 == F7_BASE)
                    kind = alureg_kind(f3);
                else if (f7 == F7_ALT && f3 == F3_ADD)
                    kind = OP_SUB;
                else if (f7 == F7_ALT && f3 == F3_SR)
                    kind = OP_SRA;
            end
            OPC_SYSTEM:
            begin
                if (instr_word == WORD_ECALL)
                begin
                    kind = OP_ECALL;
                end
                else if (instr_word == WORD_EBREAK)
                begin
                    kind = OP_EBREAK;
                end
                else
                begin
                    kind = csr_kind(f3);
                    rd   = instr_word[11:7];
                    ra   = instr_word[19:15];
                    csr  = instr_word[31:20];
                end
            end
            default:
            begin
                kind = OP_ILLEGAL;
            end
        endcase
    end

    assign target = instr_addr + imm;

    always_comb
    begin
        dec.op_kind       = kind;
        dec.dest_reg      = rd;
        dec.src_reg_a     = ra;
        dec.src_reg_b     = rb;
        dec.immediate     = imm;
        dec.branch_target = use_tgt ? target : '0;
        dec.csr_number    = csr;
        if (kind == OP_ILLEGAL)
        begin
            dec = '0;
        end
    end

endmodule

>>> src/rv32i_instruction_decoder.sv
// Channel  | Direction | Beat contents
// s_axis   | in        | tdata[31:0] instr_addr, tdata[63:32] instr_word
// m_axis   | out       | tdata: op_kind, dest_reg, src_reg_a, src_reg_b, immediate,
//          |           |        branch_target, csr_number (zero padded to 104 bits)
//
// One beat in, one beat out; a new beat is taken every cycle unless m_axis stalls.
// Each beat passes the input register, then decode logic into the result register.
// The decode path is one opcode/funct match plus one 32-bit add for the target.
// A stalled result holds in the output register while the input register still fills.
// rst_n clears both valid flags; data registers are not reset.
module rv32i_instruction_decoder
    import rvid_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [31:0] instr_addr, [63:32] instr_word
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [5:0] op_kind, [10:6] dest_reg, [15:11] src_reg_a, [20:16] src_reg_b,
    // [52:21] immediate, [84:53] branch_target, [96:85] csr_number, [103:97] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    logic            in_valid_reg;
    logic            in_valid_next;
    logic [XLEN-1:0] addr_reg;
    logic [XLEN-1:0] word_reg;
    logic            out_valid_reg;
    logic            out_valid_next;
    decode_t         out_reg;
    decode_t         dec;
    logic            in_take;
    logic            out_load;

    assign out_load      = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || out_load;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
            in_valid_next = 1'b1;
        else if (out_load)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            addr_reg <= s_axis_tdata[XLEN-1:0];
            word_reg <= s_axis_tdata[2*XLEN-1:XLEN];
        end
        if (out_load)
        begin
            out_reg <= dec;
        end
    end

    rvid_decode u_decode (
        .instr_addr (addr_reg),
        .instr_word (word_reg),
        .dec        (dec)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(M_TDATA_W - $bits(decode_t)){1'b0}}, out_reg};

endmodule

>>> verif/rv32i_instruction_decoder_tb.sv
`timescale 1ns / 1ps

module rv32i_instruction_decoder_tb;
    import rvid_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int RANDOM_INSTRS = 550;
    localparam int PHASE_LEN = 110;

    localparam logic [6:0] OPC_MISC_MEM = 7'h0f;

    localparam logic [6:0] RV_OPCODES [10] = '{
        OPC_LUI, OPC_AUIPC, OPC_JAL, OPC_JALR, OPC_BRANCH,
        OPC_LOAD, OPC_STORE, OPC_OPIMM, OPC_OP, OPC_SYSTEM
    };

    localparam logic [5:0] BRANCH_OPS [8] = '{
        OP_BEQ, OP_BNE, OP_ILLEGAL, OP_ILLEGAL, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU
    };
    localparam logic [5:0] LOAD_OPS [8] = '{
        OP_LB, OP_LH, OP_LW, OP_ILLEGAL, OP_LBU, OP_LHU, OP_ILLEGAL, OP_ILLEGAL
    };
    localparam logic [5:0] STORE_OPS [8] = '{
        OP_SB, OP_SH, OP_SW, OP_ILLEGAL, OP_ILLEGAL, OP_ILLEGAL, OP_ILLEGAL, OP_ILLEGAL
    };
    localparam logic [5:0] OPIMM_OPS [8] = '{
        OP_ADDI, OP_SLLI, OP_SLTI, OP_SLTIU, OP_XORI, OP_ILLEGAL, OP_ORI, OP_ANDI
    };
    localparam logic [5:0] OPREG_OPS [8] = '{
        OP_ADD, OP_SLL, OP_SLT, OP_SLTU, OP_XOR, OP_SRL, OP_OR, OP_AND
    };
    localparam logic [5:0] CSR_OPS [8] = '{
        OP_ILLEGAL, OP_CSRRW, OP_CSRRS, OP_CSRRC,
        OP_ILLEGAL, OP_CSRRWI, OP_CSRRSI, OP_CSRRCI
    };

    typedef struct packed {
        logic [31:0] pc;
        logic [31:0] word;
        logic        pinned;
        logic [5:0]  kind;
    } dir_row_t;

    // pinned rows carry their op_kind; every other field of those is zero
    dir_row_t dir_rows [28] = '{
        '{32'h0000_0000, 32'h0000_0000, 1'b1, OP_ILLEGAL},
        '{32'hffff_ffff, 32'hffff_ffff, 1'b1, OP_ILLEGAL},
        '{32'h0000_1000, WORD_ECALL,    1'b1, OP_ECALL},
        '{32'h0000_1004, WORD_EBREAK,   1'b1, OP_EBREAK},
        '{32'h0000_0000, 32'h0020_0073, 1'b1, OP_ILLEGAL},
        '{32'h0000_0000, 32'h0000_4073, 1'b1, OP_ILLEGAL},
        '{32'h0000_0000, 32'h0ff0_000f, 1'b1, OP_ILLEGAL},
        '{32'h0000_0000, 32'h0000_1067, 1'b1, OP_ILLEGAL},
        '{32'h0000_0000, 32'h0000_2063, 1'b1, OP_ILLEGAL},
        '{32'h0000_0000, 32'h0000_3003, 1'b1, OP_ILLEGAL},
        '{32'h0000_0000, 32'h0000_3023, 1'b1, OP_ILLEGAL},
        '{32'h0000_0000, 32'h0200_d093, 1'b1, OP_ILLEGAL},
        '{32'h0000_0000, 32'h0200_0033, 1'b1, OP_ILLEGAL},
        '{32'hffff_ffff, 32'hffff_f0b7, 1'b0, OP_ILLEGAL},
        '{32'h8000_0000, 32'h8000_0117, 1'b0, OP_ILLEGAL},
        '{32'h0000_0000, 32'h8000_006f, 1'b0, OP_ILLEGAL},
        '{32'hffff_fffe, 32'h7fff_f0ef, 1'b0, OP_ILLEGAL},
        '{32'h0000_0010, 32'hfff0_8067, 1'b0, OP_ILLEGAL},
        '{32'h0000_0004, 32'h8000_0063, 1'b0, OP_ILLEGAL},
        '{32'hffff_f000, 32'h7e00_7fe3, 1'b0, OP_ILLEGAL},
        '{32'h0000_0000, 32'hfff1_2283, 1'b0, OP_ILLEGAL},
        '{32'h0000_0000, 32'hfe11_2fa3, 1'b0, OP_ILLEGAL},
        '{32'h0000_0000, 32'hfe10_9093, 1'b0, OP_ILLEGAL},
        '{32'h0000_0000, 32'h41f0_d093, 1'b0, OP_ILLEGAL},
        '{32'h0000_0000, 32'h4020_8033, 1'b0, OP_ILLEGAL},
        '{32'h0000_0000, 32'h4020_d033, 1'b0, OP_ILLEGAL},
        '{32'h0000_0000, 32'hfff0_9073, 1'b0, OP_ILLEGAL},
        '{32'h0000_0000, 32'h3407_f073, 1'b0, OP_ILLEGAL}
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    // travels with s_axis_tdata: typed-in expectation for this beat
    logic       beat_pinned = 1'b0;
    logic [5:0] pinned_kind = OP_ILLEGAL;

    decode_t decode_q [$];
    int      fail_count = 0;
    int      quiet_cycles = 0;
    int      rx_stall = 0;
    bit      tx_steady = 1'b0;
    bit      rx_steady = 1'b0;

    rv32i_instruction_decoder DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 clk = ~clk;

    function automatic decode_t predict_decode(logic [31:0] pc, logic [31:0] w);
        decode_t     d;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [31:0] imm_i;
        logic [31:0] imm_s;
        logic [31:0] imm_b;
        logic [31:0] imm_j;
        f3    = w[14:12];
        f7    = w[31:25];
        imm_i = {{20{w[31]}}, w[31:20]};
        imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
        imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        d = '0;
        case (w[6:0])
            OPC_LUI, OPC_AUIPC:
            begin
                d.op_kind   = (w[6:0] == OPC_LUI) ? OP_LUI : OP_AUIPC;
                d.dest_reg  = w[11:7];
                d.immediate = {w[31:12], 12'b0};
            end
            OPC_JAL:
            begin
                d.op_kind       = OP_JAL;
                d.dest_reg      = w[11:7];
                d.immediate     = imm_j;
                d.branch_target = pc + imm_j;
            end
            OPC_JALR:
            begin
                if (f3 == F3_ADD)
                begin
                    d.op_kind   = OP_JALR;
                    d.dest_reg  = w[11:7];
                    d.src_reg_a = w[19:15];
                    d.immediate = imm_i;
                end
            end
            OPC_BRANCH:
            begin
                d.op_kind       = BRANCH_OPS[f3];
                d.src_reg_a     = w[19:15];
                d.src_reg_b     = w[24:20];
                d.immediate     = imm_b;
                d.branch_target = pc + imm_b;
            end
            OPC_LOAD:
            begin
                d.op_kind   = LOAD_OPS[f3];
                d.dest_reg  = w[11:7];
                d.src_reg_a = w[19:15];
                d.immediate = imm_i;
            end
            OPC_STORE:
            begin
                d.op_kind   = STORE_OPS[f3];
                d.src_reg_a = w[19:15];
                d.src_reg_b = w[24:20];
                d.immediate = imm_s;
            end
            OPC_OPIMM:
            begin
                d.dest_reg  = w[11:7];
                d.src_reg_a = w[19:15];
                d.immediate = imm_i;
                if (f3 == F3_SR)
                begin
                    if (f7 == F7_BASE)
                        d.op_kind = OP_SRLI;
                    else if (f7 == F7_ALT)
                    begin
                        d.op_kind   = OP_SRAI;
                        d.immediate = {27'b0, imm_i[4:0]};
                    end
                end
                else
                    d.op_kind = OPIMM_OPS[f3];
            end
            OPC_OP:
            begin
                d.dest_reg  = w[11:7];
                d.src_reg_a = w[19:15];
                d.src_reg_b = w[24:20];
                if (f7 == F7_BASE)
                    d.op_kind = OPREG_OPS[f3];
                else if (f7 == F7_ALT && f3 == F3_ADD)
                    d.op_kind = OP_SUB;
                else if (f7 == F7_ALT && f3 == F3_SR)
                    d.op_kind = OP_SRA;
            end
            OPC_SYSTEM:
            begin
                if (w == WORD_ECALL)
                    d.op_kind = OP_ECALL;
                else if (w == WORD_EBREAK)
                    d.op_kind = OP_EBREAK;
                else
                begin
                    d.op_kind    = CSR_OPS[f3];
                    d.dest_reg   = w[11:7];
                    d.src_reg_a  = w[19:15];
                    d.csr_number = w[31:20];
                end
            end
            default:
            begin
            end
        endcase
        if (d.op_kind == OP_ILLEGAL)
            d = '0;
        return d;
    endfunction

    // mostly valid opcodes with random fields, some exact and near-miss ecall/ebreak
    // words, some MISC_MEM opcodes, the rest raw noise
    function automatic logic [31:0] rand_instr();
        logic [31:0] w;
        int          r;
        w = $urandom;
        r = $urandom_range(0, 99);
        if (r < 3)
            w = $urandom_range(0, 1) ? WORD_ECALL : WORD_EBREAK;
        else if (r < 6)
            w = ($urandom_range(0, 1) ? WORD_ECALL : WORD_EBREAK)
                ^ (32'h1 << $urandom_range(7, 31));
        else if (r < 88)
        begin
            w[6:0] = RV_OPCODES[$urandom_range(0, 9)];
            case ($urandom_range(0, 3))
                0, 1:    w[31:25] = F7_BASE;
                2:       w[31:25] = F7_ALT;
                default: ;
            endcase
        end
        else if (r < 92)
            w[6:0] = OPC_MISC_MEM;
        return w;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        decode_t want;
        decode_t got;
        decode_t pin;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (beat_pinned)
                begin
                    pin = '0;
                    pin.op_kind = pinned_kind;
                    decode_q.push_back(pin);
                end
                else
                    decode_q.push_back(predict_decode(s_axis_tdata[31:0], s_axis_tdata[63:32]));
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[$bits(decode_t)-1:0];
                if (decode_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected beat, expected none, actual %h",
                             $time, m_axis_tdata);
                end
                else
                begin
                    want = decode_q.pop_front();
                    check_field("op_kind", 32'(want.op_kind), 32'(got.op_kind));
                    check_field("dest_reg", 32'(want.dest_reg), 32'(got.dest_reg));
                    check_field("src_reg_a", 32'(want.src_reg_a), 32'(got.src_reg_a));
                    check_field("src_reg_b", 32'(want.src_reg_b), 32'(got.src_reg_b));
                    check_field("immediate", want.immediate, got.immediate);
                    check_field("branch_target", want.branch_target, got.branch_target);
                    check_field("csr_number", 32'(want.csr_number), 32'(got.csr_number));
                    check_field("tdata pad", 32'd0,
                                32'(m_axis_tdata[M_TDATA_W-1:$bits(decode_t)]));
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || rx_steady)
            m_axis_tready <= rst_n;
        else if (rx_stall > 0)
        begin
            m_axis_tready <= 1'b0;
            rx_stall--;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            rx_stall = idle_len();
        end
    end

    task automatic send_instr(logic [31:0] pc, logic [31:0] word, logic pinned, logic [5:0] kind);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {word, pc};
        beat_pinned   <= pinned;
        pinned_kind   <= kind;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        gap = tx_steady ? 0 : idle_len();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (decode_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int phase;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_instr(dir_rows[i].pc, dir_rows[i].word, dir_rows[i].pinned, dir_rows[i].kind);
        drain();

        for (int n = 0; n < RANDOM_INSTRS; n++)
        begin
            if (n % PHASE_LEN == 0)
            begin
                phase     = n / PHASE_LEN;
                tx_steady = (phase == 1);
                rx_steady = (phase == 1) || (phase == 3);
            end
            if (n == RANDOM_INSTRS / 2)
                drain();
            send_instr($urandom, rand_instr(), 1'b0, OP_ILLEGAL);
        end
        drain();
        repeat (10) @(posedge clk);

        if (fail_count == 0)
            $display("rv32i_instruction_decoder test passed");
        else
            $display("rv32i_instruction_decoder test failed");
        $finish;
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
        $display("rv32i_instruction_decoder test failed");
        $finish;
    end

endmodule

>>> filelist.f
src/rvid_pkg.sv
src/rvid_decode.sv
src/rv32i_instruction_decoder.sv
verif/rv32i_instruction_decoder_tb.sv
